### hw/rtl/bpec_pkg.sv
// Shared types, widths and constants for the ball pair collision block.
`timescale 1ns / 1ps

package bpec_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIR_BITS  = 15;
    localparam int MASS_W    = 24;
    localparam int RAD_W     = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int MSUM_W    = MASS_W + 1;
    localparam int F_W       = FRAC_BITS + 2;   // mass factor, up to 2.0 in Q.16
    localparam int NUM_W     = 64;              // magnitude of a*t
    localparam int QUO_W     = 33;              // |g| < 2^33
    localparam int DVS_W     = 31;              // a^2 + b^2 < 2^31
    localparam int IN_W      = 264;
    localparam int OUT_W     = 136;

    localparam int DIV_BPS_DEF = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MASS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MASS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RADIUS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_RADIUS = 2'd3;

    localparam logic [MASS_W-1:0] MASS_RST   = 24'd65536;
    localparam logic [RAD_W-1:0]  RADIUS_RST = 31'd3277;

    typedef struct packed {
        logic signed [31:0] v1x;
        logic signed [31:0] v1z;
        logic signed [31:0] v2x;
        logic signed [31:0] v2z;
    } vel_t;

    typedef struct packed {
        logic signed [31:0] p1x;
        logic signed [31:0] p1z;
        logic signed [31:0] p2x;
        logic signed [31:0] p2z;
        vel_t               vel;
        logic               pocketed;
    } item_t;

    typedef struct packed {
        vel_t vel;
        logic hit;
        logic neg_x;
        logic neg_z;
    } div_pay_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] n1x;
        logic signed [31:0] n1z;
        logic signed [31:0] n2x;
        logic signed [31:0] n2z;
    } res_t;

endpackage

### hw/rtl/ball_pair_elastic_collision.sv
// An accepted item passes the front, divider and resolve stages, all registered, to m_tvalid.
// Throughput: one item per cycle while m_tready is high; every stage holds its own valid bit
// and moves on its own ready, so bubbles close up while the output register waits.
// The x and z quotients of the projection come from a pipelined divider, DIV_BPS bits a stage.
// Reset clears all valid bits and loads the registers with masses 1.0 and radii 3277.
// Mass factors follow a register write through the mass divider stages and f1/f2 registers.
`timescale 1ns / 1ps

module ball_pair_elastic_collision
    import bpec_pkg::*;
#(
    parameter int DIV_BPS = DIV_BPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // first_pos_x, first_pos_z, first_vel_x, first_vel_z, second_pos_x, second_pos_z,
    // second_vel_x, second_vel_z, second_pocketed, zero fill
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hit, new_first_vel_x, new_first_vel_z, new_second_vel_x, new_second_vel_z, zero fill
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [MASS_W-1:0] m1_reg, m2_reg;
    logic [RAD_W-1:0]  r1_reg, r2_reg;

    item_t             item;
    logic              fr_valid, fr_ready;
    logic [NUM_W-1:0]  num_x, num_z;
    logic [DVS_W-1:0]  q;
    div_pay_t          fr_pay;

    logic [1:0][DVS_W-1:0] d_rem_in, d_dvs_in, d_rem_out;
    logic [1:0][QUO_W-1:0] d_low_in, d_quo;
    logic [$bits(div_pay_t)-1:0] d_pay;
    logic                  dv_valid, dv_ready;

    logic [F_W-1:0]    f1, f2;
    res_t              res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg <= MASS_RST;
            m2_reg <= MASS_RST;
            r1_reg <= RADIUS_RST;
            r2_reg <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_MASS:    m1_reg <= cfg_data[MASS_W-1:0];
                CFG_SECOND_MASS:   m2_reg <= cfg_data[MASS_W-1:0];
                CFG_FIRST_RADIUS:  r1_reg <= cfg_data[RAD_W-1:0];
                CFG_SECOND_RADIUS: r2_reg <= cfg_data[RAD_W-1:0];
                default:           m1_reg <= m1_reg;
            endcase
        end
    end

    assign item.p1x      = s_tdata[31:0];
    assign item.p1z      = s_tdata[63:32];
    assign item.vel.v1x  = s_tdata[95:64];
    assign item.vel.v1z  = s_tdata[127:96];
    assign item.p2x      = s_tdata[159:128];
    assign item.p2z      = s_tdata[191:160];
    assign item.vel.v2x  = s_tdata[223:192];
    assign item.vel.v2z  = s_tdata[255:224];
    assign item.pocketed = s_tdata[256];

    bpec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .r1        (r1_reg),
        .r2        (r2_reg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .num_x     (num_x),
        .num_z     (num_z),
        .q         (q),
        .pay       (fr_pay)
    );

    // a*t < 2^63 and the quotient < 2^33, so the top part starts below q
    assign d_rem_in[0] = num_x[NUM_W-1:QUO_W];
    assign d_rem_in[1] = num_z[NUM_W-1:QUO_W];
    assign d_low_in[0] = num_x[QUO_W-1:0];
    assign d_low_in[1] = num_z[QUO_W-1:0];
    assign d_dvs_in[0] = q;
    assign d_dvs_in[1] = q;

    bpec_div_pipe #(
        .LANES (2),
        .DW    (DVS_W),
        .QW    (QUO_W),
        .BPS   (DIV_BPS),
        .PAY_W ($bits(div_pay_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_rem    (d_rem_in),
        .in_low    (d_low_in),
        .in_dvs    (d_dvs_in),
        .in_pay    (fr_pay),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_quo   (d_quo),
        .out_rem   (d_rem_out),
        .out_pay   (d_pay)
    );

    bpec_mass #(
        .DIV_BPS (DIV_BPS)
    ) u_mass (
        .clk   (clk),
        .rst_n (rst_n),
        .m1    (m1_reg),
        .m2    (m2_reg),
        .f1    (f1),
        .f2    (f2)
    );

    bpec_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .quo_x     (d_quo[0]),
        .quo_z     (d_quo[1]),
        .in_pay    (div_pay_t'(d_pay)),
        .f1        (f1),
        .f2        (f2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {7'b0, res.n2z, res.n2x, res.n1z, res.n1x, res.hit};

endmodule

### hw/rtl/bpec_div_pipe.sv
// Pipelined restoring divider, a few quotient bits per stage, per-stage stall.
`timescale 1ns / 1ps

module bpec_div_pipe
    import bpec_pkg::*;
#(
    parameter int LANES = 1,
    parameter int DW    = 31,
    parameter int QW    = 33,
    parameter int BPS   = 3,
    parameter int PAY_W = 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [LANES-1:0][DW-1:0]       in_rem,
    input  logic [LANES-1:0][QW-1:0]       in_low,
    input  logic [LANES-1:0][DW-1:0]       in_dvs,
    input  logic [PAY_W-1:0]               in_pay,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [LANES-1:0][QW-1:0]       out_quo,
    output logic [LANES-1:0][DW-1:0]       out_rem,
    output logic [PAY_W-1:0]               out_pay
);

    localparam int NST = (QW + BPS - 1) / BPS;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   ld;

    logic [LANES-1:0][DW-1:0] rem_reg  [NST];
    logic [LANES-1:0][QW-1:0] lq_reg   [NST];
    logic [LANES-1:0][DW-1:0] dvs_reg  [NST];
    logic [PAY_W-1:0]         pay_reg  [NST];

    logic [LANES-1:0][DW-1:0] rem_src  [NST];
    logic [LANES-1:0][QW-1:0] lq_src   [NST];
    logic [LANES-1:0][DW-1:0] dvs_src  [NST];
    logic [PAY_W-1:0]         pay_src  [NST];
    logic                     vld_src  [NST];

    logic [LANES-1:0][DW-1:0] rem_next [NST];
    logic [LANES-1:0][QW-1:0] lq_next  [NST];

    always_comb
    begin
        ld[NST] = out_ready;
        for (int st = NST - 1; st >= 0; st--)
        begin
            ld[st] = !vld_reg[st] || ld[st+1];
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = vld_reg[NST-1];
    assign out_quo   = lq_reg[NST-1];
    assign out_rem   = rem_reg[NST-1];
    assign out_pay   = pay_reg[NST-1];

    for (genvar st = 0; st < NST; st++)
    begin : g_stage
        if (st == 0)
        begin : g_first
            assign rem_src[st] = in_rem;
            assign lq_src[st]  = in_low;
            assign dvs_src[st] = in_dvs;
            assign pay_src[st] = in_pay;
            assign vld_src[st] = in_valid;
        end
        else
        begin : g_rest
            assign rem_src[st] = rem_reg[st-1];
            assign lq_src[st]  = lq_reg[st-1];
            assign dvs_src[st] = dvs_reg[st-1];
            assign pay_src[st] = pay_reg[st-1];
            assign vld_src[st] = vld_reg[st-1];
        end

        // lq holds the dividend bits still to come at the top and the
        // quotient bits already found at the bottom
        always_comb
        begin
            logic [DW:0]   rw;
            logic [DW-1:0] r;
            logic [QW-1:0] lq;
            for (int l = 0; l < LANES; l++)
            begin
                r  = rem_src[st][l];
                lq = lq_src[st][l];
                for (int j = 0; j < BPS; j++)
                begin
                    if (st * BPS + j < QW)
                    begin
                        rw = {r, lq[QW-1]};
                        lq = {lq[QW-2:0], 1'b0};
                        if (rw >= {1'b0, dvs_src[st][l]})
                        begin
                            rw    = rw - {1'b0, dvs_src[st][l]};
                            lq[0] = 1'b1;
                        end
                        r = rw[DW-1:0];
                    end
                end
                rem_next[st][l] = r;
                lq_next[st][l]  = lq;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[st] <= 1'b0;
            end
            else if (ld[st])
            begin
                vld_reg[st] <= vld_src[st];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[st])
            begin
                rem_reg[st] <= rem_next[st];
                lq_reg[st]  <= lq_next[st];
                dvs_reg[st] <= dvs_src[st];
                pay_reg[st] <= pay_src[st];
            end
        end
    end

endmodule

### hw/rtl/bpec_mass.sv
// Mass factors 2*m/(m1+m2) in Q.16, recomputed continuously from the mass registers.
`timescale 1ns / 1ps

module bpec_mass
    import bpec_pkg::*;
#(
    parameter int DIV_BPS = DIV_BPS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MASS_W-1:0] m1,
    input  logic [MASS_W-1:0] m2,
    output logic [F_W-1:0]    f1,
    output logic [F_W-1:0]    f2
);

    localparam logic [F_W-1:0] F_ONE = F_W'(1) << FRAC_BITS;
    localparam logic [F_W-1:0] F_TWO = F_W'(1) << (FRAC_BITS + 1);

    logic [MSUM_W-1:0]      msum;
    logic [0:0][MSUM_W-1:0] d_rem_in;
    logic [0:0][F_W-1:0]    d_low_in;
    logic [0:0][MSUM_W-1:0] d_dvs_in;
    logic [0:0][F_W-1:0]    d_quo;
    logic [0:0][MSUM_W-1:0] d_rem;
    logic [0:0]             d_zero;
    logic                   d_valid;

    logic [F_W-1:0] f1_reg;
    logic [F_W-1:0] f2_reg;
    logic           f_vld_reg;

    // dividend is m2 * 2^17; its top part m2/2 is below the sum when the sum is not zero
    assign msum        = {1'b0, m1} + {1'b0, m2};
    assign d_rem_in[0] = {2'b00, m2[MASS_W-1:1]};
    assign d_low_in[0] = {m2[0], {(F_W-1){1'b0}}};
    assign d_dvs_in[0] = msum;

    bpec_div_pipe #(
        .LANES (1),
        .DW    (MSUM_W),
        .QW    (F_W),
        .BPS   (DIV_BPS),
        .PAY_W (1)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (1'b1),
        .in_ready  (),
        .in_rem    (d_rem_in),
        .in_low    (d_low_in),
        .in_dvs    (d_dvs_in),
        .in_pay    (msum == '0),
        .out_valid (d_valid),
        .out_ready (1'b1),
        .out_quo   (d_quo),
        .out_rem   (d_rem),
        .out_pay   (d_zero)
    );

    // f1 = 2.0 - ceil(2*m2/msum)
    always_ff @(posedge clk)
    begin
        if (d_zero[0])
        begin
            f1_reg <= F_ONE;
            f2_reg <= F_ONE;
        end
        else
        begin
            f2_reg <= d_quo[0];
            f1_reg <= F_TWO - d_quo[0] - {{(F_W-1){1'b0}}, d_rem[0] != '0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= d_valid;
        end
    end

    assign f1 = f1_reg;
    assign f2 = f2_reg;

    a_fsum : assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg |-> ({1'b0, f1_reg} + {1'b0, f2_reg} == {1'b0, F_TWO}) ||
                      ({1'b0, f1_reg} + {1'b0, f2_reg} == {1'b0, F_TWO} - 1'b1))
        else $error("mass factors do not sum to 2.0");

endmodule

### hw/rtl/bpec_front.sv
// Hit detection, direction scaling and the numerators of the projection.
`timescale 1ns / 1ps

module bpec_front
    import bpec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  item_t            in_item,
    input  logic [RAD_W-1:0] r1,
    input  logic [RAD_W-1:0] r2,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [NUM_W-1:0] num_x,
    output logic [NUM_W-1:0] num_z,
    output logic [DVS_W-1:0] q,
    output div_pay_t         pay
);

    logic [6:0] vld_reg;
    logic [7:0] ld;

    // stage 0: differences
    logic signed [32:0] dx0_reg, dz0_reg, rvx0_reg, rvz0_reg;
    logic [31:0]        s0_reg;
    logic               poc0_reg;
    vel_t               vel0_reg;
    // stage 1: magnitudes, box test
    logic [31:0]        mdx1_reg, mdz1_reg, s1_reg;
    logic signed [32:0] dx1_reg, dz1_reg, rvx1_reg, rvz1_reg;
    logic               within1_reg;
    vel_t               vel1_reg;
    // stage 2: squares, dot products, shift count
    logic [63:0]        ex2_reg, ez2_reg, ss2_reg;
    logic signed [65:0] px2_reg, pz2_reg;
    logic [4:0]         k2_reg;
    logic [31:0]        mdx2_reg, mdz2_reg;
    logic               nx2_reg, nz2_reg, within2_reg;
    logic signed [32:0] rvx2_reg, rvz2_reg;
    vel_t               vel2_reg;
    // stage 3: hit, direction
    logic               hit3_reg;
    logic signed [15:0] a3_reg, b3_reg;
    logic signed [32:0] rvx3_reg, rvz3_reg;
    vel_t               vel3_reg;
    // stage 4: q and t
    logic [DVS_W-1:0]   q4_reg;
    logic signed [49:0] t4_reg;
    logic [14:0]        ma4_reg, mb4_reg;
    logic               na4_reg, nb4_reg, hit4_reg;
    vel_t               vel4_reg;
    // stage 5: partial products of |a|*|t|
    logic [39:0]        plx5_reg, phx5_reg, plz5_reg, phz5_reg;
    logic [DVS_W-1:0]   q5_reg;
    logic               sx5_reg, sz5_reg, hit5_reg;
    vel_t               vel5_reg;
    // stage 6: numerators
    logic [NUM_W-1:0]   nmx6_reg, nmz6_reg;
    logic [DVS_W-1:0]   q6_reg;
    div_pay_t           pay6_reg;

    logic [32:0]        mdx_full, mdz_full;
    logic [5:0]         blen;
    logic [4:0]         k_next;
    logic [31:0]        sa, sb;
    logic signed [15:0] a_next, b_next;
    logic [64:0]        d2;
    logic signed [66:0] dot;
    logic [49:0]        mt;
    logic [64:0]        nmx_sum, nmz_sum;

    always_comb
    begin
        ld[7] = out_ready;
        for (int i = 6; i >= 0; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = vld_reg[6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < 7; i++)
            begin
                if (ld[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign mdx_full = dx0_reg[32] ? 33'(-dx0_reg) : 33'(dx0_reg);
    assign mdz_full = dz0_reg[32] ? 33'(-dz0_reg) : 33'(dz0_reg);

    // smallest k with both magnitudes below 2^15 after the shift
    always_comb
    begin
        logic [31:0] m;
        m    = mdx1_reg | mdz1_reg;
        blen = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (m[i])
            begin
                blen = 6'(i + 1);
            end
        end
        k_next = (blen > 6'(DIR_BITS)) ? 5'(blen - 6'(DIR_BITS)) : 5'd0;
    end

    assign sa     = mdx2_reg >> k2_reg;
    assign sb     = mdz2_reg >> k2_reg;
    assign a_next = nx2_reg ? -$signed({1'b0, sa[14:0]}) : $signed({1'b0, sa[14:0]});
    assign b_next = nz2_reg ? -$signed({1'b0, sb[14:0]}) : $signed({1'b0, sb[14:0]});
    assign d2     = {1'b0, ex2_reg} + {1'b0, ez2_reg};
    assign dot    = 67'(px2_reg) + 67'(pz2_reg);

    assign mt      = t4_reg[49] ? 50'(-t4_reg) : 50'(t4_reg);
    assign nmx_sum = {phx5_reg, 25'b0} + {25'b0, plx5_reg};
    assign nmz_sum = {phz5_reg, 25'b0} + {25'b0, plz5_reg};

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            dx0_reg  <= 33'(in_item.p1x) - 33'(in_item.p2x);
            dz0_reg  <= 33'(in_item.p1z) - 33'(in_item.p2z);
            rvx0_reg <= 33'(in_item.vel.v1x) - 33'(in_item.vel.v2x);
            rvz0_reg <= 33'(in_item.vel.v1z) - 33'(in_item.vel.v2z);
            s0_reg   <= {1'b0, r1} + {1'b0, r2};
            poc0_reg <= in_item.pocketed;
            vel0_reg <= in_item.vel;
        end
        if (ld[1])
        begin
            mdx1_reg    <= mdx_full[31:0];
            mdz1_reg    <= mdz_full[31:0];
            s1_reg      <= s0_reg;
            dx1_reg     <= dx0_reg;
            dz1_reg     <= dz0_reg;
            rvx1_reg    <= rvx0_reg;
            rvz1_reg    <= rvz0_reg;
            within1_reg <= !poc0_reg && (mdx_full <= {1'b0, s0_reg})
                           && (mdz_full <= {1'b0, s0_reg});
            vel1_reg    <= vel0_reg;
        end
        if (ld[2])
        begin
            ex2_reg     <= mdx1_reg * mdx1_reg;
            ez2_reg     <= mdz1_reg * mdz1_reg;
            ss2_reg     <= s1_reg * s1_reg;
            px2_reg     <= rvx1_reg * dx1_reg;
            pz2_reg     <= rvz1_reg * dz1_reg;
            k2_reg      <= k_next;
            mdx2_reg    <= mdx1_reg;
            mdz2_reg    <= mdz1_reg;
            nx2_reg     <= dx1_reg[32];
            nz2_reg     <= dz1_reg[32];
            within2_reg <= within1_reg;
            rvx2_reg    <= rvx1_reg;
            rvz2_reg    <= rvz1_reg;
            vel2_reg    <= vel1_reg;
        end
        if (ld[3])
        begin
            hit3_reg <= within2_reg && (d2 != '0) && (d2 <= {1'b0, ss2_reg}) && dot[66];
            a3_reg   <= a_next;
            b3_reg   <= b_next;
            rvx3_reg <= rvx2_reg;
            rvz3_reg <= rvz2_reg;
            vel3_reg <= vel2_reg;
        end
        if (ld[4])
        begin
            ma4_reg  <= a3_reg[15] ? 15'(-a3_reg) : a3_reg[14:0];
            mb4_reg  <= b3_reg[15] ? 15'(-b3_reg) : b3_reg[14:0];
            na4_reg  <= a3_reg[15];
            nb4_reg  <= b3_reg[15];
            q4_reg   <= 31'($unsigned(32'(a3_reg) * 32'(a3_reg))
                            + $unsigned(32'(b3_reg) * 32'(b3_reg)));
            t4_reg   <= 50'(rvx3_reg) * 50'(a3_reg) + 50'(rvz3_reg) * 50'(b3_reg);
            hit4_reg <= hit3_reg;
            vel4_reg <= vel3_reg;
        end
        if (ld[5])
        begin
            plx5_reg <= 40'(ma4_reg) * 40'(mt[24:0]);
            phx5_reg <= 40'(ma4_reg) * 40'(mt[49:25]);
            plz5_reg <= 40'(mb4_reg) * 40'(mt[24:0]);
            phz5_reg <= 40'(mb4_reg) * 40'(mt[49:25]);
            sx5_reg  <= na4_reg ^ t4_reg[49];
            sz5_reg  <= nb4_reg ^ t4_reg[49];
            q5_reg   <= q4_reg;
            hit5_reg <= hit4_reg;
            vel5_reg <= vel4_reg;
        end
        if (ld[6])
        begin
            nmx6_reg       <= nmx_sum[NUM_W-1:0];
            nmz6_reg       <= nmz_sum[NUM_W-1:0];
            q6_reg         <= q5_reg;
            pay6_reg.vel   <= vel5_reg;
            pay6_reg.hit   <= hit5_reg;
            pay6_reg.neg_x <= sx5_reg;
            pay6_reg.neg_z <= sz5_reg;
        end
    end

    assign num_x = nmx6_reg;
    assign num_z = nmz6_reg;
    assign q     = q6_reg;
    assign pay   = pay6_reg;

    a_q_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] && hit4_reg |-> q4_reg != '0)
        else $error("hit with zero direction length");

    a_k_min : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (((mdx2_reg | mdz2_reg) >> k2_reg) < 32'd32768) &&
                       ((k2_reg == 5'd0) ||
                        (((mdx2_reg | mdz2_reg) >> (k2_reg - 5'd1)) >= 32'd32768)))
        else $error("direction shift is not minimal");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] && !ld[7] |=> vld_reg[6] && $stable(nmx6_reg) && $stable(q6_reg))
        else $error("stalled numerator changed");

endmodule

### hw/rtl/bpec_resolve.sv
// Scales the exchanged component by the mass factors and forms the saturated velocities.
`timescale 1ns / 1ps

module bpec_resolve
    import bpec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [QUO_W-1:0] quo_x,
    input  logic [QUO_W-1:0] quo_z,
    input  div_pay_t         in_pay,
    input  logic [F_W-1:0]   f1,
    input  logic [F_W-1:0]   f2,
    output logic             out_valid,
    input  logic             out_ready,
    output res_t             res
);

    localparam int PW = QUO_W + F_W;

    logic [1:0] vld_reg;
    logic [2:0] ld;

    logic [PW-1:0] gx2_reg, gx1_reg, gz2_reg, gz1_reg;
    div_pay_t      pay0_reg;
    res_t          res1_reg;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
        logic signed [31:0] r;
        if (x > 38'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < -38'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // v + ((neg ^ sub) ? -m : m) where m = product >> 16
    function automatic logic signed [37:0] add_scaled(input logic signed [31:0] v,
                                                      input logic [PW-1:0] p,
                                                      input logic neg, input logic sub);
        logic signed [37:0] m;
        logic signed [37:0] ve;
        m  = $signed({{(38 - (PW - FRAC_BITS)){1'b0}}, p[PW-1:FRAC_BITS]});
        ve = 38'(v);
        return ((neg ^ sub) ? ve - m : ve + m);
    endfunction

    assign ld[2]     = out_ready;
    assign ld[1]     = !vld_reg[1] || ld[2];
    assign ld[0]     = !vld_reg[0] || ld[1];
    assign in_ready  = ld[0];
    assign out_valid = vld_reg[1];
    assign res       = res1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (ld[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            gx2_reg  <= PW'(quo_x) * PW'(f2);
            gx1_reg  <= PW'(quo_x) * PW'(f1);
            gz2_reg  <= PW'(quo_z) * PW'(f2);
            gz1_reg  <= PW'(quo_z) * PW'(f1);
            pay0_reg <= in_pay;
        end
        if (ld[1])
        begin
            res1_reg.hit <= pay0_reg.hit;
            if (pay0_reg.hit)
            begin
                res1_reg.n1x <= sat32(add_scaled(pay0_reg.vel.v1x, gx2_reg,
                                                 pay0_reg.neg_x, 1'b1));
                res1_reg.n1z <= sat32(add_scaled(pay0_reg.vel.v1z, gz2_reg,
                                                 pay0_reg.neg_z, 1'b1));
                res1_reg.n2x <= sat32(add_scaled(pay0_reg.vel.v2x, gx1_reg,
                                                 pay0_reg.neg_x, 1'b0));
                res1_reg.n2z <= sat32(add_scaled(pay0_reg.vel.v2z, gz1_reg,
                                                 pay0_reg.neg_z, 1'b0));
            end
            else
            begin
                res1_reg.n1x <= pay0_reg.vel.v1x;
                res1_reg.n1z <= pay0_reg.vel.v1z;
                res1_reg.n2x <= pay0_reg.vel.v2x;
                res1_reg.n2z <= pay0_reg.vel.v2z;
            end
        end
    end

endmodule

### tb/ball_pair_checker.sv
// Checker for the ball pair collision block: watches both streams and compares results.
`timescale 1ns / 1ps

module ball_pair_checker
    import bpec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending
);

    logic [MASS_W-1:0] mass1, mass2;
    logic [RAD_W-1:0]  rad1, rad2;
    res_t              collision_q[$];

    function automatic longint mag64(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [127:0] x);
        if (x > 128'sh7fffffff)
            return 32'sh7fffffff;
        if (x < -128'sh80000000)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // product with a Q.16 factor, truncated toward zero
    function automatic logic signed [127:0] scale_q16(logic signed [127:0] g,
                                                      logic [63:0] f);
        logic signed [127:0] m;
        m = (g < 0) ? -g : g;
        m = (m * $signed({64'd0, f})) >>> FRAC_BITS;
        return (g < 0) ? -m : m;
    endfunction

    function automatic res_t resolve_collision(item_t it);
        res_t                r;
        longint              dx, dz, rvx, rvz;
        logic [63:0]         mx, mz, s, ex, ez, d2, msum, f1, f2;
        logic signed [127:0] dot, a, b, q, t, gx, gz;
        int                  k;
        logic                hit;
        dx  = longint'($signed(it.p1x)) - longint'($signed(it.p2x));
        dz  = longint'($signed(it.p1z)) - longint'($signed(it.p2z));
        rvx = longint'($signed(it.vel.v1x)) - longint'($signed(it.vel.v2x));
        rvz = longint'($signed(it.vel.v1z)) - longint'($signed(it.vel.v2z));
        mx  = mag64(dx);
        mz  = mag64(dz);
        s   = 64'(rad1) + 64'(rad2);
        // squares and their sum wrap at 64 bits; a wrapped sum is no hit
        ex  = mx * mx;
        ez  = mz * mz;
        d2  = ex + ez;
        dot = 128'(rvx) * 128'(dx) + 128'(rvz) * 128'(dz);
        hit = !it.pocketed && mx <= s && mz <= s && d2 >= ex && d2 != 0
              && d2 <= s * s && dot < 0;
        r.hit = hit;
        r.n1x = it.vel.v1x;
        r.n1z = it.vel.v1z;
        r.n2x = it.vel.v2x;
        r.n2z = it.vel.v2z;
        if (hit)
        begin
            k = 0;
            while (((mx >> k) | (mz >> k)) >= (64'd1 << DIR_BITS))
                k++;
            a = (dx < 0) ? -128'(mx >> k) : 128'(mx >> k);
            b = (dz < 0) ? -128'(mz >> k) : 128'(mz >> k);
            q = a * a + b * b;
            t = 128'(rvx) * a + 128'(rvz) * b;
            gx = (a * t) / q;
            gz = (b * t) / q;
            msum = 64'(mass1) + 64'(mass2);
            if (msum == 0)
            begin
                f1 = 64'd1 << FRAC_BITS;
                f2 = f1;
            end
            else
            begin
                f2 = ((64'(mass2) * 2) << FRAC_BITS) / msum;
                f1 = ((64'(mass1) * 2) << FRAC_BITS) / msum;
            end
            r.n1x = sat32(128'($signed(it.vel.v1x)) - scale_q16(gx, f2));
            r.n1z = sat32(128'($signed(it.vel.v1z)) - scale_q16(gz, f2));
            r.n2x = sat32(128'($signed(it.vel.v2x)) + scale_q16(gx, f1));
            r.n2z = sat32(128'($signed(it.vel.v2z)) + scale_q16(gz, f1));
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_t it;
        res_t  exp_r, got;
        if (!rst_n)
        begin
            mass1   <= MASS_RST;
            mass2   <= MASS_RST;
            rad1    <= RADIUS_RST;
            rad2    <= RADIUS_RST;
            errors  <= 0;
            pending <= 0;
            collision_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIRST_MASS:    mass1 <= cfg_data[MASS_W-1:0];
                    CFG_SECOND_MASS:   mass2 <= cfg_data[MASS_W-1:0];
                    CFG_FIRST_RADIUS:  rad1  <= cfg_data[RAD_W-1:0];
                    CFG_SECOND_RADIUS: rad2  <= cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                it.p1x      = s_tdata[31:0];
                it.p1z      = s_tdata[63:32];
                it.vel.v1x  = s_tdata[95:64];
                it.vel.v1z  = s_tdata[127:96];
                it.p2x      = s_tdata[159:128];
                it.p2z      = s_tdata[191:160];
                it.vel.v2x  = s_tdata[223:192];
                it.vel.v2z  = s_tdata[255:224];
                it.pocketed = s_tdata[256];
                collision_q.push_back(resolve_collision(it));
            end
            if (m_tvalid && m_tready)
            begin
                got.hit = m_tdata[0];
                got.n1x = m_tdata[32:1];
                got.n1z = m_tdata[64:33];
                got.n2x = m_tdata[96:65];
                got.n2z = m_tdata[128:97];
                if (collision_q.size() == 0)
                begin
                    $display("%0t: unexpected item, actual %h", $time, m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = collision_q.pop_front();
                    if (got.hit !== exp_r.hit)
                        $display("%0t: hit expected %b actual %b", $time, exp_r.hit, got.hit);
                    if (got.n1x !== exp_r.n1x)
                        $display("%0t: new_first_vel_x expected %h actual %h",
                                 $time, exp_r.n1x, got.n1x);
                    if (got.n1z !== exp_r.n1z)
                        $display("%0t: new_first_vel_z expected %h actual %h",
                                 $time, exp_r.n1z, got.n1z);
                    if (got.n2x !== exp_r.n2x)
                        $display("%0t: new_second_vel_x expected %h actual %h",
                                 $time, exp_r.n2x, got.n2x);
                    if (got.n2z !== exp_r.n2z)
                        $display("%0t: new_second_vel_z expected %h actual %h",
                                 $time, exp_r.n2z, got.n2z);
                    if (got !== exp_r)
                        errors <= errors + 1;
                end
            end
            pending <= collision_q.size();
        end
    end

endmodule

### tb/tb.sv
// Testbench top: drives ball pairs and register settings, and reports the verdict.
`timescale 1ns / 1ps

module tb;
    import bpec_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   errors, pending;
    int                   src_idle = 7, sink_idle = 70;
    int                   stall_cnt = 0;
    longint               span;

    always #5 clk = ~clk;

    ball_pair_elastic_collision dut (.*);

    ball_pair_checker chk (.*);

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_pair(input logic [31:0] p1x, p1z, v1x, v1z,
                             input logic [31:0] p2x, p2z, v2x, v2z, input logic pk);
        logic acc;
        if ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pk, v2z, v2x, p2z, p2x, v1z, v1x, p1z, p1x};
        do
        begin
            @(negedge clk);
            acc = s_tready;
            @(posedge clk);
        end
        while (!acc);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_balls(input logic [23:0] m1, m2, input logic [30:0] r1, r2);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_MASS;
        cfg_data  <= 31'(m1);
        @(posedge clk);
        cfg_index <= CFG_SECOND_MASS;
        cfg_data  <= 31'(m2);
        @(posedge clk);
        cfg_index <= CFG_FIRST_RADIUS;
        cfg_data  <= r1;
        @(posedge clk);
        cfg_index <= CFG_SECOND_RADIUS;
        cfg_data  <= r2;
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (30) @(posedge clk);
        span = longint'(r1) + longint'(r2);
        if (span > 64'd1 << 30)
            span = 64'd1 << 30;
        if (span < 16)
            span = 16;
    endtask

    function automatic logic [31:0] rnd_vel();
        if ($urandom_range(1))
            return $urandom;
        return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    function automatic logic [31:0] rnd_off();
        longint w;
        w = span + span / 8;
        return 32'(longint'($urandom_range(0, 32'(2 * w))) - w);
    endfunction

    task automatic random_pairs(input int n);
        logic [31:0] p2x, p2z;
        int          sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            p2x = $urandom;
            p2z = $urandom;
            if (sel < 20)
                send_pair($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
            else
                send_pair(p2x + rnd_off(), p2z + rnd_off(), rnd_vel(), rnd_vel(),
                          p2x, p2z, rnd_vel(), rnd_vel(), ($urandom_range(9) == 0));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);
        set_balls(24'd65536, 24'd65536, 31'd3277, 31'd3277);

        // directed: head-on, pocketed, coincident, separating, at rest, extremes
        send_pair(0, 0, 32'h10000, 0, 4000, 0, 32'hffff0000, 0, 1'b0);
        send_pair(0, 0, 32'h10000, 0, 4000, 0, 32'hffff0000, 0, 1'b1);
        send_pair(500, 500, 32'h10000, 5, 500, 500, 0, 0, 1'b0);
        send_pair(0, 0, 32'hffff0000, 0, 4000, 0, 32'h10000, 0, 1'b0);
        send_pair(0, 0, 32'h1234, 32'h55, 3000, 3000, 32'h1234, 32'h55, 1'b0);
        send_pair(0, 0, 32'h7fffffff, 32'h7fffffff, 4000, 100,
                  32'h80000000, 32'h80000000, 1'b0);
        send_pair(0, 0, 32'h80000000, 32'h80000000, 32'hfffff000, 32'hffffff00,
                  32'h7fffffff, 32'h7fffffff, 1'b0);
        send_pair(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  32'h7ffff000, 32'h80001000, 32'h7fffffff, 32'h80000000, 1'b0);
        send_pair(0, 0, 32'h10000, 32'h10000, 6554, 0, 0, 0, 1'b0);
        send_pair(0, 0, 32'h10000, 0, 4634, 4634, 0, 0, 1'b0);
        send_pair(0, 0, 32'h10000, 0, 6555, 0, 0, 0, 1'b0);
        send_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                  32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
        drain();

        // extreme radii, very unequal masses
        set_balls(24'd1, 24'hffffff, 31'h7fffffff, 31'h7fffffff);
        random_pairs(120);
        drain();
        set_balls(24'hffffff, 24'd1, 31'd0, 31'd65536);
        random_pairs(110);
        drain();

        set_balls(24'($urandom_range(1, 24'hffffff)), 24'($urandom_range(1, 24'hffffff)),
                  31'($urandom_range(0, 1 << 22)), 31'($urandom_range(0, 1 << 22)));
        src_idle = 70;
        sink_idle = 7;
        random_pairs(230);
        drain();

        set_balls(24'd65536, 24'd65536, 31'd3277, 31'd3277);
        src_idle = 0;
        sink_idle = 0;
        random_pairs(120);
        drain();
        set_balls(24'($urandom_range(1, 1 << 18)), 24'($urandom_range(1, 1 << 18)),
                  31'd0, 31'd0);
        random_pairs(108);
        drain();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
